// ===== rtl/core/hcbp_pkg.sv =====
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int MAX_CODE_LEN = 16;
  localparam int SYMBOLS      = 256;

  localparam int MODE_W  = 2;
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 16;
  localparam int LEN_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int VBITS_W = 4;
  localparam int PEND_W  = 7;
  localparam int PCNT_W  = 3;
  localparam int ACC_W   = PEND_W + CODE_W;

  localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int IDX_W     = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic              flush;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic                  valid;
    logic [CMDQ_CNT_W-1:0] level;
  } qstat_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic [VBITS_W-1:0] valid_bits;
    logic               last;
  } res_t;

endpackage

// ===== rtl/core/hcbp_front.sv =====
`timescale 1ns / 1ps

module hcbp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [hcbp_pkg::MODE_W-1:0] mode_i,
  input  logic [hcbp_pkg::SYM_W-1:0]  symbol_i,
  input  logic [hcbp_pkg::CODE_W-1:0] code_word_i,
  input  logic [hcbp_pkg::LEN_W-1:0]  code_length_i,
  input  hcbp_pkg::qstat_t            qstat_i,
  output logic                        full_o,
  output logic                        enq_o,
  output hcbp_pkg::cmd_t              cmd_o
);
  import hcbp_pkg::*;

  entry_t             mem [SYMBOLS];
  logic [SYMBOLS-1:0] hit_q;
  entry_t             rd_q;
  logic               s1_hit_q;
  logic               s1_valid_q;
  logic               s1_flush_q;

  logic              accept;
  logic              sym_ok;
  logic [IDX_W-1:0]  idx;
  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W-1:0] word_msk;
  logic              load_we;
  logic              is_encode;
  logic              is_flush;
  entry_t            wr_entry;

  assign accept = push_i & ~full_o;
  assign sym_ok = {1'b0, symbol_i} < (SYM_W + 1)'(SYMBOLS);
  assign idx    = symbol_i[IDX_W-1:0];

  always_comb begin
    is_encode = 1'b0;
    is_flush  = 1'b0;
    load_we   = 1'b0;
    unique case (mode_i)
      MODE_LOAD:   load_we   = accept & sym_ok;
      MODE_ENCODE: is_encode = sym_ok;
      MODE_FLUSH:  is_flush  = 1'b1;
      default: ;
    endcase
  end

  assign len_sat  = (code_length_i > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_length_i;
  assign word_msk = code_word_i & ~({CODE_W{1'b1}} << len_sat);
  assign wr_entry = '{len: len_sat, code: word_msk};

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem[idx] <= wr_entry;
    end
    if (accept) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= '0;
      s1_hit_q   <= 1'b0;
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
    end else begin
      if (load_we) begin
        hit_q[idx] <= 1'b1;
      end
      s1_valid_q <= accept & (is_encode | is_flush);
      if (accept) begin
        s1_flush_q <= is_flush;
        s1_hit_q   <= sym_ok & hit_q[idx];
      end
    end
  end

  // one slot held back for the beat sitting in the lookup stage
  assign full_o = (qstat_i.level + CMDQ_CNT_W'(s1_valid_q)) >= CMDQ_CNT_W'(CMDQ_DEPTH);

  assign enq_o = s1_valid_q & (s1_flush_q | (s1_hit_q & (rd_q.len != '0)));
  assign cmd_o = '{flush: s1_flush_q, len: rd_q.len, code: rd_q.code};

endmodule

// ===== rtl/core/hcbp_cmd_queue.sv =====
`timescale 1ns / 1ps

module hcbp_cmd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             enq_i,
  input  hcbp_pkg::cmd_t   cmd_i,
  input  logic             deq_i,
  output hcbp_pkg::qstat_t qstat_o,
  output hcbp_pkg::cmd_t   cmd_o
);
  import hcbp_pkg::*;

  cmd_t                  slot_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q;
  logic [CMDQ_CNT_W-1:0] cnt_q;
  logic [CMDQ_CNT_W-1:0] cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (enq_i && !deq_i) begin
      cnt_d = cnt_q + CMDQ_CNT_W'(1);
    end else if (!enq_i && deq_i) begin
      cnt_d = cnt_q - CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (enq_i) begin
        wr_ptr_q <= wr_ptr_q + CMDQ_PTR_W'(1);
      end
      if (deq_i) begin
        rd_ptr_q <= rd_ptr_q + CMDQ_PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign qstat_o = '{valid: cnt_q != '0, level: cnt_q};
  assign cmd_o   = slot_q[rd_ptr_q];

endmodule

// ===== rtl/core/hcbp_back.sv =====
`timescale 1ns / 1ps

module hcbp_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hcbp_pkg::cmd_t               cmd_i,
  input  hcbp_pkg::qstat_t             qstat_i,
  output logic                         deq_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [hcbp_pkg::BYTE_W-1:0]  out_byte_o,
  output logic [hcbp_pkg::VBITS_W-1:0] valid_bits_o,
  output logic                         last_o
);
  import hcbp_pkg::*;

  logic [PEND_W-1:0]     pbits_q;
  logic [PEND_W-1:0]     pbits_d;
  logic [PCNT_W-1:0]     pcnt_q;
  logic [PCNT_W-1:0]     pcnt_d;

  res_t                  res_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr_q;
  logic [OUTQ_PTR_W-1:0] rd_ptr_q;
  logic [OUTQ_CNT_W-1:0] ocnt_q;
  logic [OUTQ_CNT_W-1:0] ocnt_d;

  logic                  go;
  logic                  pop;
  logic [ACC_W-1:0]      acc;
  logic [LEN_W-1:0]      total;
  logic [1:0]            n_wr;
  logic [PEND_W-1:0]     rem;
  res_t                  r0;
  res_t                  r1;

  assign go    = qstat_i.valid & (ocnt_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
  assign deq_o = go;
  assign pop   = pop_i & ~empty_o;

  assign acc   = ACC_W'(pbits_q) | (ACC_W'(cmd_i.code) << pcnt_q);
  assign total = LEN_W'(pcnt_q) + cmd_i.len;

  always_comb begin
    n_wr    = 2'd0;
    pbits_d = pbits_q;
    pcnt_d  = pcnt_q;
    rem     = acc[PEND_W-1:0];
    r0      = '{out_byte: acc[BYTE_W-1:0], valid_bits: VBITS_W'(BYTE_W), last: 1'b1};
    r1      = '{out_byte: acc[2*BYTE_W-1:BYTE_W], valid_bits: VBITS_W'(BYTE_W), last: 1'b1};
    if (go) begin
      if (cmd_i.flush) begin
        n_wr    = (pcnt_q != '0) ? 2'd1 : 2'd0;
        r0      = '{out_byte: BYTE_W'(pbits_q), valid_bits: VBITS_W'(pcnt_q), last: 1'b1};
        pbits_d = '0;
        pcnt_d  = '0;
      end else begin
        priority if (total >= LEN_W'(2 * BYTE_W)) begin
          n_wr    = 2'd2;
          r0.last = 1'b0;
          rem     = acc[2*BYTE_W +: PEND_W];
        end else if (total >= LEN_W'(BYTE_W)) begin
          n_wr = 2'd1;
          rem  = acc[BYTE_W +: PEND_W];
        end else begin
          n_wr = 2'd0;
        end
        pcnt_d  = total[PCNT_W-1:0];
        pbits_d = rem & ~({PEND_W{1'b1}} << pcnt_d);
      end
    end
  end

  always_comb begin
    ocnt_d = ocnt_q + OUTQ_CNT_W'(n_wr) - OUTQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) begin
      res_q[wr_ptr_q] <= r0;
    end
    if (n_wr == 2'd2) begin
      res_q[wr_ptr_q + OUTQ_PTR_W'(1)] <= r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pbits_q  <= '0;
      pcnt_q   <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      ocnt_q   <= '0;
    end else begin
      pbits_q  <= pbits_d;
      pcnt_q   <= pcnt_d;
      wr_ptr_q <= wr_ptr_q + OUTQ_PTR_W'(n_wr);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OUTQ_PTR_W'(1);
      end
      ocnt_q <= ocnt_d;
    end
  end

  assign empty_o      = (ocnt_q == '0);
  assign out_byte_o   = res_q[rd_ptr_q].out_byte;
  assign valid_bits_o = res_q[rd_ptr_q].valid_bits;
  assign last_o       = res_q[rd_ptr_q].last;

endmodule

// ===== rtl/core/huffman_code_bit_packer.sv =====
`timescale 1ns / 1ps
// Huffman code table and LSB-first bit packer.
// Input queue side: push_i / full_o. A beat carries mode_i (load, encode,
// flush), symbol_i, code_word_i and code_length_i. Load writes the code
// table, encode appends the symbol's code bits behind the pending bits,
// flush emits the pending partial byte with zero upper bits.
// Output queue side: empty_o / pop_i. Each beat is one byte with its count
// of valid bits; last_o marks the final byte caused by one input beat.
// An encode gives zero, one or two bytes; load and empty cases give none.
// An input beat passes the table read stage, then the command queue, then
// the packer, which writes its bytes into the result queue.
// Throughput: one input beat per cycle while full_o is low; the result side drains one byte per
// cycle, so two-byte encodes are bounded by the pop rate. The packer runs
// only while the 4-entry result queue has room for two bytes.
// Reset clears the pending bits, both queues and the table valid bits, so
// every symbol reads as empty until loaded. No clearing pass is needed.
// When the receiver stalls the result queue fills, the packer waits, the
// 4-entry command queue fills and full_o rises.

module huffman_code_bit_packer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [hcbp_pkg::MODE_W-1:0]  mode_i,
  input  logic [hcbp_pkg::SYM_W-1:0]   symbol_i,
  input  logic [hcbp_pkg::CODE_W-1:0]  code_word_i,
  input  logic [hcbp_pkg::LEN_W-1:0]   code_length_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [hcbp_pkg::BYTE_W-1:0]  out_byte_o,
  output logic [hcbp_pkg::VBITS_W-1:0] valid_bits_o,
  output logic                         last_o
);
  import hcbp_pkg::*;

  qstat_t qstat;
  cmd_t   enq_cmd;
  cmd_t   head_cmd;
  logic   enq;
  logic   deq;

  hcbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .mode_i        (mode_i),
    .symbol_i      (symbol_i),
    .code_word_i   (code_word_i),
    .code_length_i (code_length_i),
    .qstat_i       (qstat),
    .full_o        (full_o),
    .enq_o         (enq),
    .cmd_o         (enq_cmd)
  );

  hcbp_cmd_queue u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (enq),
    .cmd_i   (enq_cmd),
    .deq_i   (deq),
    .qstat_o (qstat),
    .cmd_o   (head_cmd)
  );

  hcbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (head_cmd),
    .qstat_i      (qstat),
    .deq_o        (deq),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .out_byte_o   (out_byte_o),
    .valid_bits_o (valid_bits_o),
    .last_o       (last_o)
  );

endmodule

// ===== rtl/core/hcbp_checker.sv =====
`timescale 1ns / 1ps

module hcbp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         empty_o,
  input logic                         pop_i,
  input logic [hcbp_pkg::BYTE_W-1:0]  out_byte_o,
  input logic [hcbp_pkg::VBITS_W-1:0] valid_bits_o,
  input logic                         last_o
);
  import hcbp_pkg::*;

  // count of valid bits is 1..8
  a_vbits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (valid_bits_o != '0) && (valid_bits_o <= VBITS_W'(BYTE_W)))
    else $error("valid_bits out of range");

  // a partial byte only comes from a flush, which is always the last beat
  a_partial_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && (valid_bits_o != VBITS_W'(BYTE_W))) |-> last_o)
    else $error("partial byte without last");

  // bits above the valid count are zero
  a_partial_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> ((out_byte_o >> valid_bits_o) == '0))
    else $error("stray bits above valid count");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(out_byte_o) && $stable(valid_bits_o)
      && $stable(last_o)))
    else $error("waiting beat changed");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty_o      (empty_o),
  .pop_i        (pop_i),
  .out_byte_o   (out_byte_o),
  .valid_bits_o (valid_bits_o),
  .last_o       (last_o)
);

// ===== verif/hcbp_byte_checker.sv =====
`timescale 1ns / 1ps

module hcbp_byte_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         full_i,
  input  logic [hcbp_pkg::MODE_W-1:0]  mode_i,
  input  logic [hcbp_pkg::SYM_W-1:0]   symbol_i,
  input  logic [hcbp_pkg::CODE_W-1:0]  code_word_i,
  input  logic [hcbp_pkg::LEN_W-1:0]   code_length_i,
  input  logic                         empty_i,
  input  logic                         pop_i,
  input  logic [hcbp_pkg::BYTE_W-1:0]  out_byte_i,
  input  logic [hcbp_pkg::VBITS_W-1:0] valid_bits_i,
  input  logic                         last_i,
  output int                           errors_o,
  output int                           waiting_o
);
  import hcbp_pkg::*;

  entry_t            code_tab [SYMBOLS];
  logic [PEND_W-1:0] pend_bits;
  logic [PCNT_W-1:0] pend_cnt;
  res_t              bytes_due [$];
  int                err_cnt;

  task automatic pack_beat(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] len_sat;
    logic [31:0]      keep;
    logic [ACC_W-1:0] acc;
    entry_t           e;
    res_t             r;
    int               total;
    int               nb;
    case (mode)
      MODE_LOAD: begin
        if (int'(sym) < SYMBOLS) begin
          len_sat = (int'(len) > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : len;
          keep    = (32'h1 << len_sat) - 32'h1;
          e.len   = len_sat;
          e.code  = word & keep[CODE_W-1:0];
          code_tab[sym] = e;
        end
      end
      MODE_ENCODE: begin
        if (int'(sym) < SYMBOLS) begin
          e = code_tab[sym];
          if (e.len != '0) begin
            acc   = ACC_W'(pend_bits) | (ACC_W'(e.code) << pend_cnt);
            total = int'(pend_cnt) + int'(e.len);
            nb    = (total >= 16) ? 2 : (total >= 8) ? 1 : 0;
            for (int i = 0; i < nb; i++) begin
              r.out_byte   = acc[BYTE_W-1:0];
              r.valid_bits = VBITS_W'(8);
              r.last       = (i == nb - 1);
              bytes_due.push_back(r);
              acc   = acc >> 8;
              total -= 8;
            end
            pend_cnt  = PCNT_W'(total);
            pend_bits = PEND_W'(acc & ((ACC_W'(1) << total) - ACC_W'(1)));
          end
        end
      end
      MODE_FLUSH: begin
        if (pend_cnt != '0) begin
          r.out_byte   = BYTE_W'(pend_bits);
          r.valid_bits = VBITS_W'(pend_cnt);
          r.last       = 1'b1;
          bytes_due.push_back(r);
        end
        pend_bits = '0;
        pend_cnt  = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_b;
    if (!rst_ni) begin
      foreach (code_tab[i]) code_tab[i] = '0;
      pend_bits = '0;
      pend_cnt  = '0;
      bytes_due.delete();
      err_cnt   = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (bytes_due.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected beat, expected none, got byte %h bits %0d last %b",
                   $time, out_byte_i, valid_bits_i, last_i);
        end else begin
          exp_b = bytes_due.pop_front();
          if (exp_b.out_byte !== out_byte_i) begin
            err_cnt++;
            $display("%0t: out_byte expected %h got %h", $time, exp_b.out_byte, out_byte_i);
          end
          if (exp_b.valid_bits !== valid_bits_i) begin
            err_cnt++;
            $display("%0t: valid_bits expected %0d got %0d", $time, exp_b.valid_bits,
                     valid_bits_i);
          end
          if (exp_b.last !== last_i) begin
            err_cnt++;
            $display("%0t: last expected %b got %b", $time, exp_b.last, last_i);
          end
        end
      end
      if (push_i && !full_i) pack_beat(mode_i, symbol_i, code_word_i, code_length_i);
    end
    errors_o  <= err_cnt;
    waiting_o <= bytes_due.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hcbp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RUN_LIMIT   = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 325;

  logic                clk_i;
  logic                rst_ni;
  logic                push_i;
  logic                full_o;
  logic [MODE_W-1:0]   mode_i;
  logic [SYM_W-1:0]    symbol_i;
  logic [CODE_W-1:0]   code_word_i;
  logic [LEN_W-1:0]    code_length_i;
  logic                empty_o;
  logic                pop_i;
  logic [BYTE_W-1:0]   out_byte_o;
  logic [VBITS_W-1:0]  valid_bits_o;
  logic                last_o;

  int                  errors;
  int                  waiting;
  int                  cycles;
  int                  gap_pct;
  int                  stall_pct;
  bit                  hold_req;
  bit                  loaded [SYMBOLS];
  logic [SYM_W-1:0]    loaded_q [$];

  huffman_code_bit_packer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .mode_i       (mode_i),
    .symbol_i     (symbol_i),
    .code_word_i  (code_word_i),
    .code_length_i(code_length_i),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .out_byte_o   (out_byte_o),
    .valid_bits_o (valid_bits_o),
    .last_o       (last_o)
  );

  hcbp_byte_checker byte_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_i       (full_o),
    .mode_i       (mode_i),
    .symbol_i     (symbol_i),
    .code_word_i  (code_word_i),
    .code_length_i(code_length_i),
    .empty_i      (empty_o),
    .pop_i        (pop_i),
    .out_byte_i   (out_byte_o),
    .valid_bits_i (valid_bits_o),
    .last_i       (last_o),
    .errors_o     (errors),
    .waiting_o    (waiting)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    pop_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        pop_i = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic offer(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                       input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < gap_pct) begin
      push_i        = 1'b0;
      mode_i        = MODE_W'($urandom);
      symbol_i      = SYM_W'($urandom);
      code_word_i   = CODE_W'($urandom);
      code_length_i = LEN_W'($urandom);
      @(negedge clk_i);
    end
    push_i        = 1'b1;
    mode_i        = mode;
    symbol_i      = sym;
    code_word_i   = word;
    code_length_i = len;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    @(negedge clk_i);
    if (mode == MODE_LOAD && !loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_q.push_back(sym);
    end
  endtask

  task automatic random_item();
    int               pick;
    logic [SYM_W-1:0] s;
    logic [LEN_W-1:0] l;
    pick = $urandom_range(99);
    if (pick < 12) begin
      if ($urandom_range(9) == 0)       l = LEN_W'($urandom_range(31, 17));
      else if ($urandom_range(14) == 0) l = '0;
      else                              l = LEN_W'($urandom_range(16, 1));
      offer(MODE_LOAD, SYM_W'($urandom), CODE_W'($urandom), l);
    end else if (pick < 88) begin
      s = SYM_W'($urandom);
      if (loaded_q.size() > 0 && $urandom_range(9) != 0)
        s = loaded_q[$urandom_range(loaded_q.size() - 1)];
      offer(MODE_ENCODE, s, CODE_W'($urandom), LEN_W'($urandom));
    end else if (pick < 96) begin
      offer(MODE_FLUSH, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
    end else begin
      offer(MODE_UNUSED, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    push_i        = 1'b0;
    mode_i        = MODE_LOAD;
    symbol_i      = '0;
    code_word_i   = '0;
    code_length_i = '0;
    gap_pct       = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    offer(MODE_ENCODE, 8'h00, 16'hFFFF, 5'd31);  // nothing loaded yet
    offer(MODE_FLUSH,  8'hFF, 16'h0000, 5'd0);   // nothing pending
    offer(MODE_UNUSED, 8'hFF, 16'hFFFF, 5'd31);
    offer(MODE_LOAD,   8'h00, 16'hFFFF, 5'd16);
    offer(MODE_LOAD,   8'hFF, 16'hA5C3, 5'd31);  // saturates
    offer(MODE_LOAD,   8'h55, 16'hFFFF, 5'd3);   // stray high bits dropped
    offer(MODE_LOAD,   8'hAA, 16'h0001, 5'd1);
    offer(MODE_LOAD,   8'h80, 16'hFFFF, 5'd0);   // empty entry
    offer(MODE_LOAD,   8'h33, 16'h0000, 5'd7);
    offer(MODE_LOAD,   8'h0F, 16'h1234, 5'd17);
    offer(MODE_ENCODE, 8'h55, 16'h0000, 5'd0);
    offer(MODE_ENCODE, 8'h00, 16'h0000, 5'd0);
    offer(MODE_ENCODE, 8'hFF, 16'h0000, 5'd0);
    offer(MODE_ENCODE, 8'h80, 16'h0000, 5'd0);
    offer(MODE_ENCODE, 8'hAA, 16'h0000, 5'd0);
    offer(MODE_ENCODE, 8'hAA, 16'h0000, 5'd0);
    offer(MODE_ENCODE, 8'h0F, 16'h0000, 5'd0);
    offer(MODE_FLUSH,  8'h00, 16'h0000, 5'd0);
    offer(MODE_FLUSH,  8'h00, 16'h0000, 5'd0);
    offer(MODE_ENCODE, 8'h33, 16'h0000, 5'd0);
    offer(MODE_ENCODE, 8'h00, 16'h0000, 5'd0);  // 7 pending + 16
    offer(MODE_FLUSH,  8'h00, 16'h0000, 5'd0);
    offer(MODE_ENCODE, 8'hAA, 16'hFFFF, 5'd31);
    offer(MODE_UNUSED, 8'h00, 16'h0000, 5'd0);
    offer(MODE_FLUSH,  8'hFF, 16'hFFFF, 5'd31);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 80; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 80; end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 100) hold_req = 1'b1;
        random_item();
      end
    end

    push_i    = 1'b0;
    gap_pct   = 0;
    stall_pct = 0;
    while (waiting != 0 || hold_req) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0 && waiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
